[hw/rtl/hpagc_pkg.sv]
// ----------------------------------------------------------------------------
// hpagc_pkg
// Shared types, register map codes and constants of the high-pass / AGC chain.
// ----------------------------------------------------------------------------
package hpagc_pkg;

  // default sample width of the top level
  localparam int SAMPLE_BITS_DEF = 16;

  // configuration port
  localparam int ADDR_W = 5;
  localparam int DATA_W = 32;
  localparam int REG_IDX_W = 3;

  // register indexes
  localparam logic [REG_IDX_W-1:0] REG_HP_ENABLE      = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_HP_COEF_B0     = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_HP_COEF_A1     = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_AGC_ENABLE     = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_TARGET_LEVEL   = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_GAIN_LIMIT     = 3'd5;
  localparam logic [REG_IDX_W-1:0] REG_ATTACK_FACTOR  = 3'd6;
  localparam logic [REG_IDX_W-1:0] REG_RELEASE_FACTOR = 3'd7;

  // register reset values
  localparam logic [22:0] RST_HP_COEF_B0     = 23'd4194304;
  localparam logic [23:0] RST_HP_COEF_A1     = 24'd0;
  localparam logic [15:0] RST_TARGET_LEVEL   = 16'd6554;
  localparam logic [23:0] RST_GAIN_LIMIT     = 24'd655360;
  localparam logic [15:0] RST_ATTACK_FACTOR  = 16'd65128;
  localparam logic [15:0] RST_RELEASE_FACTOR = 16'd65495;

  // fixed point constants
  localparam int PEAK_W = 17;                       // peak level, at most 1.0 in Q.16
  localparam logic [PEAK_W-1:0] GAIN_ONE17 = 17'h10000;
  localparam logic [23:0] GAIN_ONE = 24'h010000;
  localparam logic [PEAK_W-1:0] PEAK_FLOOR = 17'd6;

  // divider sizes
  localparam int DVD_W = 32;
  localparam int DSR_W = PEAK_W;

  typedef struct packed {
    logic        hp_enable;
    logic [22:0] hp_coef_b0;
    logic [23:0] hp_coef_a1;
    logic        agc_enable;
    logic [15:0] target_level;
    logic [23:0] gain_limit;
    logic [15:0] attack_factor;
    logic [15:0] release_factor;
  } cfg_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_status_t;

endpackage

[hw/rtl/hpagc_regs.sv]
// ----------------------------------------------------------------------------
// hpagc_regs
// APB-style configuration register file of the high-pass / AGC chain.
// ----------------------------------------------------------------------------
module hpagc_regs (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [hpagc_pkg::ADDR_W-1:0] paddr,
  input  logic [hpagc_pkg::DATA_W-1:0] pwdata,
  output logic [hpagc_pkg::DATA_W-1:0] prdata,
  output logic                        pready,
  output hpagc_pkg::cfg_t             cfg_o
);
  import hpagc_pkg::*;

  cfg_t                 cfg_q;
  logic [REG_IDX_W-1:0] idx;
  logic                 wr_en;

  assign pready = 1'b1;
  assign idx    = paddr[ADDR_W-1:2];
  assign wr_en  = psel & penable & pwrite & pready;
  assign cfg_o  = cfg_q;

  // register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.hp_enable      <= 1'b0;
      cfg_q.hp_coef_b0     <= RST_HP_COEF_B0;
      cfg_q.hp_coef_a1     <= RST_HP_COEF_A1;
      cfg_q.agc_enable     <= 1'b0;
      cfg_q.target_level   <= RST_TARGET_LEVEL;
      cfg_q.gain_limit     <= RST_GAIN_LIMIT;
      cfg_q.attack_factor  <= RST_ATTACK_FACTOR;
      cfg_q.release_factor <= RST_RELEASE_FACTOR;
    end else if (wr_en) begin
      case (idx)
        REG_HP_ENABLE:      cfg_q.hp_enable      <= pwdata[0];
        REG_HP_COEF_B0:     cfg_q.hp_coef_b0     <= pwdata[22:0];
        REG_HP_COEF_A1:     cfg_q.hp_coef_a1     <= pwdata[23:0];
        REG_AGC_ENABLE:     cfg_q.agc_enable     <= pwdata[0];
        REG_TARGET_LEVEL:   cfg_q.target_level   <= pwdata[15:0];
        REG_GAIN_LIMIT:     cfg_q.gain_limit     <= pwdata[23:0];
        REG_ATTACK_FACTOR:  cfg_q.attack_factor  <= pwdata[15:0];
        REG_RELEASE_FACTOR: cfg_q.release_factor <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  // read mux
  always_comb begin
    case (idx)
      REG_HP_ENABLE:      prdata = {31'd0, cfg_q.hp_enable};
      REG_HP_COEF_B0:     prdata = {9'd0, cfg_q.hp_coef_b0};
      REG_HP_COEF_A1:     prdata = {{8{cfg_q.hp_coef_a1[23]}}, cfg_q.hp_coef_a1};
      REG_AGC_ENABLE:     prdata = {31'd0, cfg_q.agc_enable};
      REG_TARGET_LEVEL:   prdata = {16'd0, cfg_q.target_level};
      REG_GAIN_LIMIT:     prdata = {8'd0, cfg_q.gain_limit};
      REG_ATTACK_FACTOR:  prdata = {16'd0, cfg_q.attack_factor};
      REG_RELEASE_FACTOR: prdata = {16'd0, cfg_q.release_factor};
      default:            prdata = '0;
    endcase
  end

endmodule

[hw/rtl/hpagc_mul.sv]
// ----------------------------------------------------------------------------
// hpagc_mul
// Shared signed multiplier with a registered product.
// ----------------------------------------------------------------------------
module hpagc_mul #(
  parameter int MW = 26
) (
  input  logic                   clk_i,
  input  logic signed [MW-1:0]   a_i,
  input  logic signed [MW-1:0]   b_i,
  output logic signed [2*MW-1:0] prod_o
);

  logic signed [2*MW-1:0] prod_q;

  // product register, payload only
  always_ff @(posedge clk_i) begin
    prod_q <= a_i * b_i;
  end

  assign prod_o = prod_q;

endmodule

[hw/rtl/hpagc_div.sv]
// ----------------------------------------------------------------------------
// hpagc_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module hpagc_div #(
  parameter int DVD_W = hpagc_pkg::DVD_W,
  parameter int DSR_W = hpagc_pkg::DSR_W
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [DVD_W-1:0]          dividend_i,
  input  logic [DSR_W-1:0]          divisor_i,
  output logic [DVD_W-1:0]          quotient_o,
  output hpagc_pkg::div_status_t    status_o
);
  import hpagc_pkg::*;

  localparam int CW = $clog2(DVD_W);

  logic [DSR_W:0]   rem_q;
  logic [DVD_W-1:0] quo_q;
  logic [DSR_W-1:0] dsr_q;
  logic [CW-1:0]    cnt_q;
  logic             busy_q;
  logic             done_q;
  logic [DSR_W:0]   rem_sh;
  logic             ge;

  // shift in the next dividend bit and trial subtract
  assign rem_sh = {rem_q[DSR_W-1:0], quo_q[DVD_W-1]};
  assign ge     = (rem_sh >= {1'b0, dsr_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CW'(DVD_W - 1);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= dividend_i;
      dsr_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= ge ? (rem_sh - {1'b0, dsr_q}) : rem_sh;
      quo_q <= {quo_q[DVD_W-2:0], ge};
    end
  end

  assign quotient_o    = quo_q;
  assign status_o.busy = busy_q;
  assign status_o.done = done_q;

endmodule

[hw/rtl/highpass_peak_agc_chain.sv]
// ----------------------------------------------------------------------------
// highpass_peak_agc_chain
// First-order high-pass followed by a peak-tracking AGC, run by a sequencer
// over one shared multiplier and one iterative divider.
// ----------------------------------------------------------------------------
// Samples are handled one at a time: a new sample is taken only after the last
// one has been loaded into the output register, where it waits while the next
// one is taken. The AGC gain target uses the divider's 32 one-bit steps when
// the peak is above the floor. Reset clears all filter and AGC state
// (gain to 1.0) and loads the register defaults.
module highpass_peak_agc_chain #(
  parameter int SAMPLE_BITS = hpagc_pkg::SAMPLE_BITS_DEF
) (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  // sample_in
  input  logic                                    s_axis_tvalid,
  output logic                                    s_axis_tready,
  input  logic [((SAMPLE_BITS+7)/8)*8-1:0]        s_axis_tdata,
  input  logic                                    s_axis_tlast,
  // sample_out, gain_now
  output logic                                    m_axis_tvalid,
  input  logic                                    m_axis_tready,
  output logic [((SAMPLE_BITS+24+7)/8)*8-1:0]     m_axis_tdata,
  output logic                                    m_axis_tlast,
  input  logic                                    psel,
  input  logic                                    penable,
  input  logic                                    pwrite,
  input  logic [hpagc_pkg::ADDR_W-1:0]            paddr,
  input  logic [hpagc_pkg::DATA_W-1:0]            pwdata,
  output logic [hpagc_pkg::DATA_W-1:0]            prdata,
  output logic                                    pready
);
  import hpagc_pkg::*;

  localparam int SB       = SAMPLE_BITS;
  localparam int OUT_TW   = ((SB + 24 + 7) / 8) * 8;
  localparam int MW       = (SB + 2 > 26) ? SB + 2 : 26;
  localparam int PW       = 2 * MW;
  localparam int AW       = PW + 2;
  localparam int HP_SH    = 24 - SB;
  localparam int SMP_FRAC = SB - 1;

  localparam logic [SB-1:0] SMP_MAX = {1'b0, {(SB-1){1'b1}}};
  localparam logic [SB-1:0] SMP_MIN = {1'b1, {(SB-1){1'b0}}};
  localparam logic signed [AW-1:0] HP_POS  = AW'(4194304);
  localparam logic signed [AW-1:0] HP_NEG  = -AW'(4194304);
  localparam logic signed [AW-1:0] HP_RND  = AW'(8388607);
  localparam logic signed [PW-1:0] SC_RND  = PW'(4194303);
  localparam logic signed [PW-1:0] AP_RND  = PW'(65535);
  localparam logic signed [AW-1:0] MIX_RND = AW'(32768);

  typedef enum logic [4:0] {
    ST_IDLE, ST_HP_MUL_B0, ST_HP_MUL_A1, ST_HP_CLAMP, ST_HP_MUL_Y, ST_HP_SCALE,
    ST_AGC_LEVEL, ST_AGC_DECAY, ST_AGC_TARGET, ST_AGC_DIV, ST_AGC_MIX_A,
    ST_AGC_MIX_B, ST_AGC_MIX_C, ST_AGC_APPLY, ST_AGC_SCALE, ST_AGC_SAT, ST_FINISH
  } state_e;

  cfg_t        cfg;
  div_status_t div_st;
  state_e      state_q;

  logic [SB-1:0]          smp_q;
  logic                   last_q;
  logic [SB-1:0]          xprev_q;
  logic [23:0]            yprev_q;
  logic [PEAK_W-1:0]      peak_q;
  logic [23:0]            gain_q;
  logic [23:0]            tg_q;
  logic [15:0]            c_q;
  logic signed [AW-1:0]   acc_q;
  logic                   out_valid_q;
  logic [SB-1:0]          smp_out_q;
  logic [23:0]            gain_out_q;
  logic                   last_out_q;

  logic signed [MW-1:0]   mul_a, mul_b;
  logic signed [PW-1:0]   prod;
  logic [DVD_W-1:0]       quo;
  logic                   div_start;

  logic signed [AW-1:0]   prod_ext;
  logic signed [SB:0]     dx;
  logic signed [AW-1:0]   hp_sum, hp_div;
  logic [23:0]            hp_y;
  logic signed [PW-1:0]   sc_div;
  logic signed [PW-1:0]   ap_div;
  logic [SB-1:0]          ap_sat;
  logic [SB:0]            mag;
  logic [SB+16:0]         lvl_full;
  logic [PEAK_W-1:0]      lvl;
  logic [PEAK_W-1:0]      one_minus_c;
  logic signed [AW-1:0]   mix_sum;
  logic                   out_load;

  hpagc_regs u_regs (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready),
    .cfg_o  (cfg)
  );

  hpagc_mul #(.MW(MW)) u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .prod_o(prod)
  );

  hpagc_div #(.DVD_W(DVD_W), .DSR_W(DSR_W)) u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_start),
    .dividend_i({cfg.target_level, 16'd0}),
    .divisor_i (peak_q),
    .quotient_o(quo),
    .status_o  (div_st)
  );

  // high-pass arithmetic: truncate toward zero, clamp to [-1, 1]
  assign prod_ext = {{2{prod[PW-1]}}, prod};
  assign dx       = {smp_q[SB-1], smp_q} - {xprev_q[SB-1], xprev_q};
  assign hp_sum   = acc_q - (prod_ext <<< 1);
  assign hp_div   = $signed(hp_sum + (hp_sum[AW-1] ? HP_RND : AW'(0))) >>> 23;
  always_comb begin
    if (hp_div > HP_POS) begin
      hp_y = HP_POS[23:0];
    end else if (hp_div < HP_NEG) begin
      hp_y = HP_NEG[23:0];
    end else begin
      hp_y = hp_div[23:0];
    end
  end
  assign sc_div = $signed(prod + (prod[PW-1] ? SC_RND : PW'(0))) >>> 22;

  // agc arithmetic
  assign mag         = smp_q[SB-1] ? -{smp_q[SB-1], smp_q} : {1'b0, smp_q};
  assign lvl_full    = {mag, 16'd0} >> SMP_FRAC;
  assign lvl         = lvl_full[PEAK_W-1:0];
  assign one_minus_c = GAIN_ONE17 - {1'b0, c_q};
  assign mix_sum     = acc_q + prod_ext + MIX_RND;
  assign ap_div      = $signed(prod + (prod[PW-1] ? AP_RND : PW'(0))) >>> 16;
  always_comb begin
    if (ap_div > $signed({{(PW-SB){1'b0}}, SMP_MAX})) begin
      ap_sat = SMP_MAX;
    end else if (ap_div < $signed({{(PW-SB){1'b1}}, SMP_MIN})) begin
      ap_sat = SMP_MIN;
    end else begin
      ap_sat = ap_div[SB-1:0];
    end
  end

  // multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      ST_HP_MUL_B0: begin
        mul_a = {{(MW-23){1'b0}}, cfg.hp_coef_b0};
        mul_b = {{(MW-SB-1){dx[SB]}}, dx};
      end
      ST_HP_MUL_A1: begin
        mul_a = {{(MW-24){cfg.hp_coef_a1[23]}}, cfg.hp_coef_a1};
        mul_b = {{(MW-24){yprev_q[23]}}, yprev_q};
      end
      ST_HP_MUL_Y: begin
        mul_a = {{(MW-24){yprev_q[23]}}, yprev_q};
        mul_b = {{(MW-SB){1'b0}}, SMP_MAX};
      end
      ST_AGC_LEVEL: begin
        mul_a = {{(MW-PEAK_W){1'b0}}, peak_q};
        mul_b = {{(MW-16){1'b0}}, cfg.release_factor};
      end
      ST_AGC_MIX_B: begin
        mul_a = {{(MW-16){1'b0}}, c_q};
        mul_b = {{(MW-24){1'b0}}, gain_q};
      end
      ST_AGC_MIX_C: begin
        mul_a = {{(MW-PEAK_W){1'b0}}, one_minus_c};
        mul_b = {{(MW-24){1'b0}}, tg_q};
      end
      ST_AGC_SCALE: begin
        mul_a = {{(MW-SB){smp_q[SB-1]}}, smp_q};
        mul_b = {{(MW-24){1'b0}}, gain_q};
      end
      default: ;
    endcase
  end

  assign div_start     = (state_q == ST_AGC_TARGET) && (peak_q > PEAK_FLOOR);
  assign out_load      = (state_q == ST_FINISH) && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = (state_q == ST_IDLE);

  // sequencer with its state and output registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      smp_q       <= '0;
      last_q      <= 1'b0;
      xprev_q     <= '0;
      yprev_q     <= '0;
      peak_q      <= '0;
      gain_q      <= GAIN_ONE;
      tg_q        <= '0;
      c_q         <= '0;
      acc_q       <= '0;
      out_valid_q <= 1'b0;
      smp_out_q   <= '0;
      gain_out_q  <= '0;
      last_out_q  <= 1'b0;
    end else begin
      if (m_axis_tready && !out_load) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (s_axis_tvalid) begin
            smp_q  <= s_axis_tdata[SB-1:0];
            last_q <= s_axis_tlast;
            if (cfg.hp_enable) begin
              state_q <= ST_HP_MUL_B0;
            end else if (cfg.agc_enable) begin
              state_q <= ST_AGC_LEVEL;
            end else begin
              state_q <= ST_FINISH;
            end
          end
        end
        ST_HP_MUL_B0: state_q <= ST_HP_MUL_A1;
        ST_HP_MUL_A1: begin
          acc_q   <= prod_ext <<< HP_SH;
          state_q <= ST_HP_CLAMP;
        end
        ST_HP_CLAMP: begin
          yprev_q <= hp_y;
          xprev_q <= smp_q;
          state_q <= ST_HP_MUL_Y;
        end
        ST_HP_MUL_Y: state_q <= ST_HP_SCALE;
        ST_HP_SCALE: begin
          smp_q   <= sc_div[SB-1:0];
          state_q <= cfg.agc_enable ? ST_AGC_LEVEL : ST_FINISH;
        end
        ST_AGC_LEVEL: begin
          if (lvl > peak_q) begin
            peak_q  <= lvl;
            state_q <= ST_AGC_TARGET;
          end else begin
            state_q <= ST_AGC_DECAY;
          end
        end
        ST_AGC_DECAY: begin
          peak_q  <= prod[16+PEAK_W-1:16];
          state_q <= ST_AGC_TARGET;
        end
        ST_AGC_TARGET: begin
          if (div_start) begin
            state_q <= ST_AGC_DIV;
          end else begin
            tg_q    <= (GAIN_ONE > cfg.gain_limit) ? cfg.gain_limit : GAIN_ONE;
            state_q <= ST_AGC_MIX_A;
          end
        end
        ST_AGC_DIV: begin
          if (div_st.done) begin
            tg_q    <= (quo > {8'd0, cfg.gain_limit}) ? cfg.gain_limit : quo[23:0];
            state_q <= ST_AGC_MIX_A;
          end
        end
        ST_AGC_MIX_A: begin
          c_q     <= (tg_q < gain_q) ? cfg.attack_factor : cfg.release_factor;
          state_q <= ST_AGC_MIX_B;
        end
        ST_AGC_MIX_B: state_q <= ST_AGC_MIX_C;
        ST_AGC_MIX_C: begin
          acc_q   <= prod_ext;
          state_q <= ST_AGC_APPLY;
        end
        ST_AGC_APPLY: begin
          // new smoothed gain, the apply product is issued from it next
          gain_q  <= mix_sum[39:16];
          state_q <= ST_AGC_SCALE;
        end
        ST_AGC_SCALE: state_q <= ST_AGC_SAT;
        ST_AGC_SAT: begin
          smp_q   <= ap_sat;
          state_q <= ST_FINISH;
        end
        ST_FINISH: begin
          if (out_load) begin
            smp_out_q   <= smp_q;
            gain_out_q  <= gain_q;
            last_out_q  <= last_q;
            out_valid_q <= 1'b1;
            state_q     <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = OUT_TW'({gain_out_q, smp_out_q});
  assign m_axis_tlast  = last_out_q;

  // divider runs only while no new sample can enter
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_st.busy |-> !s_axis_tready)
    else $error("divider busy while input ready");

  // smoothed gain changes only in its update step
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (gain_q != $past(gain_q)) |-> ($past(state_q) == ST_AGC_APPLY))
    else $error("gain changed outside update step");

  // peak level never exceeds full scale
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    peak_q <= GAIN_ONE17)
    else $error("peak level above full scale");

endmodule

[sim/highpass_peak_agc_chain_tb.sv]
// ----------------------------------------------------------------------------
// highpass_peak_agc_chain_tb
// Self-checking bench for the high-pass / peak AGC chain. Samples go in over
// the slave stream, coefficients are set over APB while the chain is idle, and
// every output transaction is compared against a bit-true fixed point model of
// the high-pass filter and the gain normalizer kept inside this bench.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module highpass_peak_agc_chain_tb;
  import hpagc_pkg::*;

  localparam int SETTLE_CYCLES = 80;

  typedef struct {
    logic signed [15:0] smp;
    logic [23:0]        gain;
    logic               last;
  } chain_out_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [15:0]         s_axis_tdata = '0;   // sample_in
  logic                s_axis_tlast = 1'b0; // block_end
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [39:0]         m_axis_tdata;        // sample_out [15:0], gain_now [39:16]
  logic                m_axis_tlast;        // block_end_out
  logic                psel = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite = 1'b0;
  logic [ADDR_W-1:0]   paddr = '0;
  logic [DATA_W-1:0]   pwdata = '0;
  logic [DATA_W-1:0]   prdata;
  logic                pready;

  highpass_peak_agc_chain dut (.*);

  // clock
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // shadow configuration
  bit          hp_on, agc_on;
  longint      b0_q22, a1_q22, tgt_lvl, gain_cap, attack_c, release_c;
  // shadow filter and gain state
  longint      x_prev, y_prev, peak_q16, gain_q16;

  chain_out_t  pending_q[$];
  int          errors = 0;
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;
  int          hold_request = 0;
  int          hold_left = 0;

  // high-pass plus gain normalizer, updates shadow state
  function automatic chain_out_t predict_chain(logic signed [15:0] x_in, logic last_in);
    chain_out_t r;
    longint s, acc, y, mag, lvl, tg, c;
    s = x_in;
    if (hp_on) begin
      acc = b0_q22 * (s - x_prev) * 256 - a1_q22 * y_prev * 2;
      y = acc / 8388608;
      if (y > 4194304) y = 4194304;
      if (y < -4194304) y = -4194304;
      x_prev = s;
      y_prev = y;
      s = (y * 32767) / 4194304;
    end
    if (agc_on) begin
      mag = (s < 0) ? -s : s;
      lvl = (mag << 16) >> 15;
      if (lvl > peak_q16) peak_q16 = lvl;
      else peak_q16 = (peak_q16 * release_c) >> 16;
      tg = 65536;
      if (peak_q16 > 6) tg = (tgt_lvl << 16) / peak_q16;
      if (tg > gain_cap) tg = gain_cap;
      c = (tg < gain_q16) ? attack_c : release_c;
      gain_q16 = ((c * gain_q16 + (65536 - c) * tg + 32768) >> 16) & 64'hFFFFFF;
      s = (s * gain_q16) / 65536;
      if (s > 32767) s = 32767;
      if (s < -32768) s = -32768;
    end
    r.smp = s[15:0];
    r.gain = gain_q16[23:0];
    r.last = last_in;
    return r;
  endfunction

  // receiver ready, with long hold-off counted here
  always @(posedge clk_i) begin
    if (hold_request > 0 && hold_left == 0) begin
      hold_left <= hold_request;
      m_axis_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // result checker
  always @(posedge clk_i) begin
    chain_out_t e;
    if (m_axis_tvalid && m_axis_tready) begin
      if (pending_q.size() == 0) begin
        errors++;
        $display("%0t unexpected transaction: expected none, actual %h last %b",
                 $time, m_axis_tdata, m_axis_tlast);
      end else begin
        e = pending_q.pop_front();
        if (m_axis_tdata[15:0] !== e.smp) begin
          errors++;
          $display("%0t sample_out: expected %0d, actual %0d", $time, e.smp,
                   $signed(m_axis_tdata[15:0]));
        end
        if (m_axis_tdata[39:16] !== e.gain) begin
          errors++;
          $display("%0t gain_now: expected %0d, actual %0d", $time, e.gain,
                   m_axis_tdata[39:16]);
        end
        if (m_axis_tlast !== e.last) begin
          errors++;
          $display("%0t block_end_out: expected %b, actual %b", $time, e.last,
                   m_axis_tlast);
        end
      end
    end
  end

  // run limit
  initial begin
    #4000000;
    $display("CHECKS FAILED");
    $finish;
  end

  // one sample transaction, valid stays high between back-to-back samples;
  // ready is looked at mid-cycle so the following rising edge is the accept
  task automatic send_sample(logic signed [15:0] x, logic last);
    if ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(5, 1)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= x;
    s_axis_tlast <= last;
    @(negedge clk_i);
    while (!s_axis_tready) @(negedge clk_i);
    @(posedge clk_i);
    pending_q.push_back(predict_chain(x, last));
  endtask

  // stop offering and wait until every result has come back
  task automatic drain;
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic apb_write(logic [REG_IDX_W-1:0] idx, logic [31:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= ADDR_W'({idx, 2'b00});
    pwdata <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_HP_ENABLE:      hp_on = val[0];
      REG_HP_COEF_B0:     b0_q22 = val[22:0];
      REG_HP_COEF_A1:     a1_q22 = $signed(val[23:0]);
      REG_AGC_ENABLE:     agc_on = val[0];
      REG_TARGET_LEVEL:   tgt_lvl = val[15:0];
      REG_GAIN_LIMIT:     gain_cap = val[23:0];
      REG_ATTACK_FACTOR:  attack_c = val[15:0];
      default:            release_c = val[15:0];
    endcase
  endtask

  task automatic set_chain(bit hp, bit agc, logic [31:0] b0, logic [31:0] a1,
                           logic [31:0] tgt, logic [31:0] cap, logic [31:0] att,
                           logic [31:0] rel);
    apb_write(REG_HP_ENABLE, {31'd0, hp});
    apb_write(REG_HP_COEF_B0, b0);
    apb_write(REG_HP_COEF_A1, a1);
    apb_write(REG_AGC_ENABLE, {31'd0, agc});
    apb_write(REG_TARGET_LEVEL, tgt);
    apb_write(REG_GAIN_LIMIT, cap);
    apb_write(REG_ATTACK_FACTOR, att);
    apb_write(REG_RELEASE_FACTOR, rel);
  endtask

  // random sample with a random amplitude, now and then an exact extreme
  function automatic logic signed [15:0] pick_sample();
    logic [31:0] raw;
    raw = $urandom;
    case ($urandom_range(9))
      0:       return 16'sh8000;
      1:       return 16'sh7fff;
      2:       return '0;
      default: return $signed(raw[15:0]) >>> $urandom_range(15, 0);
    endcase
  endfunction

  // pass-through with both stages off after reset
  task automatic test_bypass;
    send_sample(16'sh8000, 1'b0);
    send_sample(16'sh7fff, 1'b1);
    send_sample(16'sh0000, 1'b0);
    send_sample(-16'sd1, 1'b1);
    drain();
  endtask

  // high-pass at coefficient extremes and at one usual setting
  task automatic test_highpass;
    set_chain(1, 0, 32'h7fffff, 32'h800000, 6554, 655360, 65128, 65495);
    send_sample(16'sh7fff, 1'b0);
    send_sample(16'sh8000, 1'b0);
    send_sample(16'sh7fff, 1'b1);
    drain();
    set_chain(1, 0, 0, 32'h7fffff, 6554, 655360, 65128, 65495);
    send_sample(16'sh1234, 1'b0);
    send_sample(16'sh8000, 1'b1);
    drain();
    set_chain(1, 0, 4194304, 32'hc00000, 6554, 655360, 65128, 65495);
    send_sample(16'sh4000, 1'b0);
    send_sample(16'sh4000, 1'b0);
    send_sample(16'shc000, 1'b1);
    drain();
  endtask

  // gain normalizer: silence under the floor, full scale, cap below one,
  // frozen gain once disabled
  task automatic test_agc;
    set_chain(0, 1, 4194304, 0, 65535, 32768, 0, 65535);
    send_sample(16'sh0000, 1'b0);
    send_sample(16'sh0001, 1'b0);
    send_sample(16'sh8000, 1'b0);
    send_sample(16'sh7fff, 1'b1);
    drain();
    set_chain(1, 1, 4194304, 32'hc2a000, 0, 24'hffffff, 65535, 0);
    send_sample(16'sh0003, 1'b0);
    send_sample(16'sh8000, 1'b0);
    send_sample(16'sh0000, 1'b1);
    drain();
    set_chain(0, 0, 4194304, 0, 6554, 655360, 65128, 65495);
    send_sample(16'sh7fff, 1'b0);
    send_sample(16'sh8000, 1'b1);
    drain();
  endtask

  // random configuration, extremes mixed with usual audio settings
  task automatic random_config;
    logic [31:0] b0, a1, tgt, cap, att, rel;
    b0  = ($urandom_range(3) == 0) ? $urandom_range(8388607) : $urandom_range(4194304, 3800000);
    a1  = ($urandom_range(3) == 0) ? $urandom : -$urandom_range(4194304, 3500000);
    tgt = ($urandom_range(4) == 0) ? $urandom_range(65535) : $urandom_range(20000, 2000);
    cap = ($urandom_range(4) == 0) ? $urandom_range(24'hffffff) : $urandom_range(1000000, 65536);
    att = ($urandom_range(4) == 0) ? $urandom_range(65535) : $urandom_range(65535, 60000);
    rel = ($urandom_range(4) == 0) ? $urandom_range(65535) : $urandom_range(65535, 62000);
    set_chain($urandom_range(3) != 0, $urandom_range(3) != 0, b0, a1, tgt, cap, att, rel);
  endtask

  // random bursts of loud and quiet samples under each idling pattern
  task automatic test_random_stream;
    int mode, cfg_n, k;
    int idle_pct[4] = '{0, 51, 0, 21};
    int stall_pct[4] = '{0, 0, 51, 21};
    for (mode = 0; mode < 4; mode++) begin
      send_idle_pct = idle_pct[mode];
      recv_stall_pct = stall_pct[mode];
      for (cfg_n = 0; cfg_n < 2; cfg_n++) begin
        random_config();
        for (k = 0; k < 110; k++) send_sample(pick_sample(), $urandom_range(7) == 0);
        drain();
      end
    end
    send_idle_pct = 0;
    recv_stall_pct = 0;
  endtask

  // receiver holds off while samples keep coming, so the input stalls
  task automatic test_backpressure;
    int k;
    set_chain(1, 1, 4100000, -4000000, 8000, 655360, 65128, 65495);
    hold_request <= 400;
    @(posedge clk_i);
    hold_request <= 0;
    for (k = 0; k < 40; k++) send_sample(pick_sample(), k[2:0] == 3'd7);
    drain();
  endtask

  initial begin
    hp_on = 0;
    agc_on = 0;
    b0_q22 = 4194304;
    a1_q22 = 0;
    tgt_lvl = 6554;
    gain_cap = 655360;
    attack_c = 65128;
    release_c = 65495;
    x_prev = 0;
    y_prev = 0;
    peak_q16 = 0;
    gain_q16 = 65536;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_bypass();
    test_highpass();
    test_agc();
    test_backpressure();
    test_random_stream();

    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
